/* rtl/irt_pkg.sv */
package irt_pkg;

    localparam int ENTRIES_DEF  = 16;
    localparam int REF_BITS_DEF = 32;

    localparam int ACTION_W = 3;
    localparam int NUMBER_W = 32;
    localparam int REF_W    = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 4;

    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 40;

    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam action_t ACT_APPEND       = 3'd0;
    localparam action_t ACT_REMOVE       = 3'd1;
    localparam action_t ACT_READ_FIRST   = 3'd2;
    localparam action_t ACT_READ_LAST    = 3'd3;
    localparam action_t ACT_WRITE_FIRST  = 3'd4;
    localparam action_t ACT_WRITE_LAST   = 3'd5;
    localparam action_t ACT_NEWEST_LAST  = 3'd6;
    localparam action_t ACT_OLDEST_FIRST = 3'd7;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;
    localparam status_t ST_SPAN  = 2'd3;

endpackage

/* rtl/irt_slot_map.sv */
module irt_slot_map #(
    parameter int ENTRIES = irt_pkg::ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic [irt_pkg::NUMBER_W-1:0]  num_m1,
    output logic [$clog2(ENTRIES)-1:0]    slot
);

    localparam int AW    = $clog2(ENTRIES);
    localparam int NW    = irt_pkg::NUMBER_W;
    localparam int SHIFT = NW + AW - 1;
    localparam logic [NW-1:0] RECIP = NW'((64'd1 << SHIFT) / 64'(ENTRIES));
    localparam logic [AW:0]   ENT_R = (AW+1)'(ENTRIES);

    logic [2*NW-1:0] prod_reg;
    logic [AW-1:0]   slot_reg;
    logic [AW:0]     q_low;
    logic [AW:0]     q_times_e;
    logic [AW:0]     rem_raw;
    logic [AW:0]     rem_fix;

    // quotient estimate is low by at most one; remainder fits in AW+1 bits
    assign q_low     = prod_reg[SHIFT +: AW+1];
    assign q_times_e = (AW+1)'(q_low * ENT_R);
    assign rem_raw   = num_m1[AW:0] - q_times_e;
    assign rem_fix   = (rem_raw >= ENT_R) ? (rem_raw - ENT_R) : rem_raw;

    always_ff @(posedge clk)
    begin
        prod_reg <= {{NW{1'b0}}, num_m1} * {{NW{1'b0}}, RECIP};
        slot_reg <= rem_fix[AW-1:0];
    end

    assign slot = slot_reg;

endmodule

/* rtl/indexed_ring_table_core.sv */
// Ring table of ENTRIES slots, each a (first, last) reference pair, kept in two
// single-port synchronous memories with head, tail and count registers. One
// command per transfer; one result transfer per command. After acceptance, a
// command passes through S_MUL and S_MOD, which map the one-based number to a
// slot (reciprocal multiply and correction), S_EXEC, which checks and issues
// the memory access and pointer update, and S_DONE, which loads the output
// register with the read data. The next command is accepted the cycle after
// the result register is loaded, so a new command is never taken before the
// last one is through; a result still waiting in the output register holds
// the last step until it is taken. Errors (full, empty, outside live span)
// leave the state as is.
module indexed_ring_table_core #(
    parameter int ENTRIES  = irt_pkg::ENTRIES_DEF,
    parameter int REF_BITS = irt_pkg::REF_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // action[2:0], train_number[34:3], first_ref[66:35], last_ref[98:67], zero pad
    input  logic [irt_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // ref_out[31:0], status[33:32], occupancy[37:34], zero pad
    output logic [irt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    localparam int AW = $clog2(ENTRIES);
    localparam int NW = irt_pkg::NUMBER_W;
    localparam int RW = irt_pkg::REF_W;
    localparam logic [AW-1:0] LAST_SLOT = AW'(ENTRIES - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_MOD  = 3'd2;
    localparam logic [2:0] S_EXEC = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    localparam logic [1:0] RSEL_ZERO  = 2'd0;
    localparam logic [1:0] RSEL_FIRST = 2'd1;
    localparam logic [1:0] RSEL_LAST  = 2'd2;

    logic [2:0]               state_reg, state_next;
    logic [AW-1:0]            head_reg, head_next;
    logic [AW-1:0]            tail_reg, tail_next;
    logic [AW-1:0]            count_reg, count_next;
    logic                     out_valid_reg, out_valid_next;

    irt_pkg::action_t         action_reg;
    logic [NW-1:0]            num_m1_reg;
    logic [RW-1:0]            first_in_reg;
    logic [RW-1:0]            last_in_reg;
    irt_pkg::status_t         status_reg, status_next;
    logic [1:0]               rsel_reg, rsel_next;
    logic [REF_BITS-1:0]      rd_first_reg;
    logic [REF_BITS-1:0]      rd_last_reg;
    logic [RW-1:0]            out_ref_reg;
    irt_pkg::status_t         out_status_reg;
    logic [irt_pkg::OCC_W-1:0] out_occ_reg;

    logic [REF_BITS-1:0]      first_mem [ENTRIES];
    logic [REF_BITS-1:0]      last_mem  [ENTRIES];

    logic [AW-1:0]            slot;
    logic [AW-1:0]            mem_addr;
    logic                     we_first, we_last;
    logic                     in_span;
    logic [AW-1:0]            head_inc, tail_inc, tail_dec;
    logic                     in_xfer, out_free, exec_en;
    logic [RW-1:0]            ref_sel;

    irt_slot_map #(
        .ENTRIES (ENTRIES)
    ) u_slot_map (
        .clk    (clk),
        .num_m1 (num_m1_reg),
        .slot   (slot)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign exec_en       = (state_reg == S_EXEC);

    assign head_inc = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? LAST_SLOT : tail_reg - 1'b1;

    always_comb
    begin
        if (head_reg <= tail_reg)
        begin
            in_span = (slot >= head_reg) && (slot < tail_reg);
        end
        else
        begin
            in_span = (slot >= head_reg) || (slot < tail_reg);
        end
    end

    always_comb
    begin
        status_next = irt_pkg::ST_OK;
        rsel_next   = RSEL_ZERO;
        mem_addr    = slot;
        we_first    = 1'b0;
        we_last     = 1'b0;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        case (action_reg)
            irt_pkg::ACT_APPEND:
            begin
                if (count_reg < LAST_SLOT)
                begin
                    mem_addr   = tail_reg;
                    we_first   = exec_en;
                    we_last    = exec_en;
                    tail_next  = tail_inc;
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    status_next = irt_pkg::ST_FULL;
                end
            end
            irt_pkg::ACT_REMOVE:
            begin
                if (count_reg != '0)
                begin
                    head_next  = head_inc;
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    status_next = irt_pkg::ST_EMPTY;
                end
            end
            irt_pkg::ACT_READ_FIRST, irt_pkg::ACT_READ_LAST,
            irt_pkg::ACT_WRITE_FIRST, irt_pkg::ACT_WRITE_LAST:
            begin
                if (!in_span)
                begin
                    status_next = irt_pkg::ST_SPAN;
                end
                else if (action_reg == irt_pkg::ACT_READ_FIRST)
                begin
                    rsel_next = RSEL_FIRST;
                end
                else if (action_reg == irt_pkg::ACT_READ_LAST)
                begin
                    rsel_next = RSEL_LAST;
                end
                else if (action_reg == irt_pkg::ACT_WRITE_FIRST)
                begin
                    we_first = exec_en;
                end
                else
                begin
                    we_last = exec_en;
                end
            end
            irt_pkg::ACT_NEWEST_LAST:
            begin
                // empty ring reads as zero
                if (count_reg != '0)
                begin
                    mem_addr  = tail_dec;
                    rsel_next = RSEL_LAST;
                end
            end
            default:
            begin
                if (count_reg != '0)
                begin
                    mem_addr  = head_reg;
                    rsel_next = RSEL_FIRST;
                end
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:  state_next = S_MOD;
            S_MOD:  state_next = S_EXEC;
            S_EXEC: state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if ((state_reg == S_DONE) && out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (exec_en)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
            end
        end
    end

    always_comb
    begin
        case (rsel_reg)
            RSEL_FIRST: ref_sel = RW'(rd_first_reg);
            RSEL_LAST:  ref_sel = RW'(rd_last_reg);
            default:    ref_sel = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            action_reg   <= s_axis_tdata[2:0];
            num_m1_reg   <= s_axis_tdata[34:3] - 32'd1;
            first_in_reg <= s_axis_tdata[66:35];
            last_in_reg  <= s_axis_tdata[98:67];
        end
        if (exec_en)
        begin
            status_reg <= status_next;
            rsel_reg   <= rsel_next;
        end
        if ((state_reg == S_DONE) && out_free)
        begin
            out_ref_reg    <= ref_sel;
            out_status_reg <= status_reg;
            out_occ_reg    <= irt_pkg::OCC_W'(count_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_first)
        begin
            first_mem[mem_addr] <= REF_BITS'(first_in_reg);
        end
        if (we_last)
        begin
            last_mem[mem_addr] <= REF_BITS'(last_in_reg);
        end
        rd_first_reg <= first_mem[mem_addr];
        rd_last_reg  <= last_mem[mem_addr];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_occ_reg, out_status_reg, out_ref_reg};

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LAST_SLOT)
        else $error("live count beyond capacity");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) == (head_reg == tail_reg))
        else $error("count disagrees with head and tail");

    a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_en && (status_next != irt_pkg::ST_OK)) |=>
            ($stable(head_reg) && $stable(tail_reg) && $stable(count_reg)))
        else $error("failed command changed pointers");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        exec_en |-> (slot <= LAST_SLOT))
        else $error("mapped slot out of range");
`endif

endmodule

/* tb/sv/tb_indexed_ring_table_core.sv */
`timescale 1ns / 100ps

module tb_indexed_ring_table_core;

    import irt_pkg::*;

    localparam int ENTRIES    = ENTRIES_DEF;
    localparam int QUIET_MAX  = 2000;
    localparam int RAND_ITEMS = 800;
    localparam int NUM_PROBES = 25;

    typedef struct packed {
        logic [3:0]  occ;
        status_t     st;
        logic [31:0] ref_val;
    } table_result_t;

    typedef struct packed {
        action_t       act;
        logic [31:0]   num;
        logic [31:0]   fref;
        logic [31:0]   lref;
        logic [4:0]    reps;
        logic          typed;
        table_result_t want;
    } probe_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    logic [31:0] ring_first [ENTRIES];
    logic [31:0] ring_last [ENTRIES];
    int          ring_head;
    int          ring_tail;
    int          ring_count;

    table_result_t pending_results [$];
    int            errors = 0;
    int            commands_sent = 0;
    int            results_checked = 0;
    int            status_seen [4] = '{0, 0, 0, 0};
    bit            src_idle = 1'b1;
    bit            snk_idle = 1'b1;
    int            stall_left;
    int            quiet_cycles;

    probe_row_t probe_rows [0:NUM_PROBES-1] = '{
        '{ACT_REMOVE,       32'd1,          32'h0,        32'h0,        5'd1,  1'b1,
          '{4'd0,  ST_EMPTY, 32'h0}},
        '{ACT_READ_FIRST,   32'd1,          32'h0,        32'h0,        5'd1,  1'b1,
          '{4'd0,  ST_SPAN,  32'h0}},
        '{ACT_NEWEST_LAST,  32'd1,          32'h0,        32'h0,        5'd1,  1'b1,
          '{4'd0,  ST_OK,    32'h0}},
        '{ACT_OLDEST_FIRST, 32'd1,          32'h0,        32'h0,        5'd1,  1'b1,
          '{4'd0,  ST_OK,    32'h0}},
        '{ACT_WRITE_LAST,   32'd0,          32'h0,        32'hFFFFFFFF, 5'd1,  1'b1,
          '{4'd0,  ST_SPAN,  32'h0}},
        '{ACT_APPEND,       32'd0,          32'hFFFFFFFF, 32'h0,        5'd1,  1'b1,
          '{4'd1,  ST_OK,    32'h0}},
        '{ACT_APPEND,       32'd0,          32'h0,        32'hFFFFFFFF, 5'd1,  1'b1,
          '{4'd2,  ST_OK,    32'h0}},
        '{ACT_READ_FIRST,   32'd1,          32'h0,        32'h0,        5'd1,  1'b1,
          '{4'd2,  ST_OK,    32'hFFFFFFFF}},
        '{ACT_READ_LAST,    32'd2,          32'h0,        32'h0,        5'd1,  1'b1,
          '{4'd2,  ST_OK,    32'hFFFFFFFF}},
        '{ACT_READ_FIRST,   32'd0,          32'h0,        32'h0,        5'd1,  1'b1,
          '{4'd2,  ST_SPAN,  32'h0}},
        '{ACT_READ_LAST,    32'hFFFFFFFF,   32'h0,        32'h0,        5'd1,  1'b1,
          '{4'd2,  ST_SPAN,  32'h0}},
        '{ACT_WRITE_FIRST,  32'd2,          32'hA5A5A5A5, 32'h0,        5'd1,  1'b1,
          '{4'd2,  ST_OK,    32'h0}},
        '{ACT_WRITE_LAST,   32'd17,         32'h0,        32'h5A5A5A5A, 5'd1,  1'b1,
          '{4'd2,  ST_OK,    32'h0}},
        '{ACT_READ_FIRST,   32'd18,         32'h0,        32'h0,        5'd1,  1'b1,
          '{4'd2,  ST_OK,    32'hA5A5A5A5}},
        '{ACT_READ_LAST,    32'd1,          32'h0,        32'h0,        5'd1,  1'b1,
          '{4'd2,  ST_OK,    32'h5A5A5A5A}},
        '{ACT_NEWEST_LAST,  32'd0,          32'h0,        32'h0,        5'd1,  1'b1,
          '{4'd2,  ST_OK,    32'hFFFFFFFF}},
        '{ACT_OLDEST_FIRST, 32'd0,          32'h0,        32'h0,        5'd1,  1'b1,
          '{4'd2,  ST_OK,    32'hFFFFFFFF}},
        '{ACT_WRITE_FIRST,  32'd3,          32'h11111111, 32'h0,        5'd1,  1'b1,
          '{4'd2,  ST_SPAN,  32'h0}},
        '{ACT_REMOVE,       32'd0,          32'h0,        32'h0,        5'd1,  1'b1,
          '{4'd1,  ST_OK,    32'h0}},
        '{ACT_READ_LAST,    32'd1,          32'h0,        32'h0,        5'd1,  1'b1,
          '{4'd1,  ST_SPAN,  32'h0}},
        '{ACT_APPEND,       32'd0,          32'h12345678, 32'h87654321, 5'd14, 1'b0,
          '{4'd0,  ST_OK,    32'h0}},
        '{ACT_APPEND,       32'd0,          32'hDEADBEEF, 32'hCAFEF00D, 5'd1,  1'b1,
          '{4'd15, ST_FULL,  32'h0}},
        '{ACT_READ_LAST,    32'd0,          32'h0,        32'h0,        5'd1,  1'b0,
          '{4'd0,  ST_OK,    32'h0}},
        '{ACT_REMOVE,       32'd0,          32'h0,        32'h0,        5'd15, 1'b0,
          '{4'd0,  ST_OK,    32'h0}},
        '{ACT_REMOVE,       32'd0,          32'h0,        32'h0,        5'd1,  1'b1,
          '{4'd0,  ST_EMPTY, 32'h0}}
    };

    indexed_ring_table_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic bit slot_is_live(int slot);
        if (ring_head <= ring_tail)
            return slot >= ring_head && slot < ring_tail;
        return slot >= ring_head || slot < ring_tail;
    endfunction

    function automatic table_result_t table_step(action_t act, logic [31:0] num,
                                                 logic [31:0] fref, logic [31:0] lref);
        table_result_t res;
        int            slot;
        res  = '0;
        res.st = ST_OK;
        slot = int'((num - 32'd1) % ENTRIES);
        case (act)
            ACT_APPEND:
            begin
                if (ring_count < ENTRIES - 1)
                begin
                    ring_first[ring_tail] = fref;
                    ring_last[ring_tail]  = lref;
                    ring_tail  = (ring_tail + 1) % ENTRIES;
                    ring_count = ring_count + 1;
                end
                else
                    res.st = ST_FULL;
            end
            ACT_REMOVE:
            begin
                if (ring_count > 0)
                begin
                    ring_first[ring_head] = '0;
                    ring_last[ring_head]  = '0;
                    ring_head  = (ring_head + 1) % ENTRIES;
                    ring_count = ring_count - 1;
                end
                else
                    res.st = ST_EMPTY;
            end
            ACT_READ_FIRST, ACT_READ_LAST, ACT_WRITE_FIRST, ACT_WRITE_LAST:
            begin
                if (!slot_is_live(slot))
                    res.st = ST_SPAN;
                else if (act == ACT_READ_FIRST)
                    res.ref_val = ring_first[slot];
                else if (act == ACT_READ_LAST)
                    res.ref_val = ring_last[slot];
                else if (act == ACT_WRITE_FIRST)
                    ring_first[slot] = fref;
                else
                    ring_last[slot] = lref;
            end
            ACT_NEWEST_LAST:
            begin
                if (ring_tail != ring_head)
                    res.ref_val = ring_last[(ring_tail + ENTRIES - 1) % ENTRIES];
                else
                    res.ref_val = ring_last[ring_tail];
            end
            default:
                res.ref_val = ring_first[ring_head];
        endcase
        res.occ = ring_count[3:0];
        return res;
    endfunction

    task automatic push_command(action_t act, logic [31:0] num, logic [31:0] fref,
                                logic [31:0] lref, bit typed, table_result_t want);
        table_result_t predicted;
        int            gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, lref, fref, num, act};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = table_step(act, num, fref, lref);
        pending_results.push_back(typed ? want : predicted);
        commands_sent++;
        gap = src_idle ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // in-span numbers mostly, with the slots just outside the span and raw values mixed in
    function automatic logic [31:0] pick_number();
        int          sel;
        int          slot;
        logic [31:0] upper;
        sel   = $urandom_range(0, 99);
        upper = $urandom();
        if (sel < 70 && ring_count > 0)
            slot = (ring_head + $urandom_range(0, ring_count - 1)) % ENTRIES;
        else if (sel < 80)
            slot = ring_tail;
        else if (sel < 88)
            slot = (ring_head + ENTRIES - 1) % ENTRIES;
        else
            return $urandom();
        return {upper[27:0], 4'(slot)} + 32'd1;
    endfunction

    function automatic action_t pick_action(int mode);
        int pick;
        int add_lim;
        int del_lim;
        pick = $urandom_range(0, 99);
        case (mode)
            0:       begin add_lim = 45; del_lim = 50; end
            1:       begin add_lim = 5;  del_lim = 50; end
            default: begin add_lim = 20; del_lim = 35; end
        endcase
        if (pick < add_lim)
            return ACT_APPEND;
        if (pick < del_lim)
            return ACT_REMOVE;
        return action_t'(ACT_READ_FIRST + $urandom_range(0, 5));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        table_result_t want;
        table_result_t got;
        int            hold;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 1;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            got = table_result_t'(m_axis_tdata[37:0]);
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with none expected: ref %h status %0d occ %0d",
                         $time, got.ref_val, got.st, got.occ);
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                status_seen[want.st]++;
                if (got.ref_val !== want.ref_val)
                begin
                    errors++;
                    $display("%0t: ref_out expected %h actual %h",
                             $time, want.ref_val, got.ref_val);
                end
                if (got.st !== want.st)
                begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
                end
                if (got.occ !== want.occ)
                begin
                    errors++;
                    $display("%0t: occupancy expected %0d actual %0d",
                             $time, want.occ, got.occ);
                end
                if (m_axis_tdata[39:38] !== 2'b00)
                begin
                    errors++;
                    $display("%0t: pad bits expected 0 actual %b", $time, m_axis_tdata[39:38]);
                end
            end
            if (results_checked % 50 == 0)
                snk_idle = $urandom_range(0, 2) != 0;
            hold = snk_idle ? $urandom_range(0, 14) : 0;
            stall_left <= hold;
            if (hold > 0)
                m_axis_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            if (stall_left == 1)
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_MAX)
        begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_MAX);
            $display("tb_indexed_ring_table_core: errors");
            $finish;
        end
    end

    initial
    begin
        probe_row_t    row;
        table_result_t none;
        int            mode;
        none = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            ring_first[i] = '0;
            ring_last[i]  = '0;
        end
        ring_head    = 0;
        ring_tail    = 0;
        ring_count   = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < NUM_PROBES; p++)
        begin
            row = probe_rows[p];
            for (int r = 0; r < row.reps; r++)
                push_command(row.act, row.num, row.fref + r, row.lref ^ r, row.typed, row.want);
        end

        mode = 2;
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if (i % 40 == 0)
                mode = $urandom_range(0, 2);
            if (i % 60 == 0)
                src_idle = $urandom_range(0, 2) != 0;
            if (i == RAND_ITEMS / 2 && pending_results.size() != 0)
            begin
                // let the table drain completely before continuing
                s_axis_tvalid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            push_command(pick_action(mode), pick_number(), $urandom(), $urandom(), 1'b0, none);
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("%0d commands sent, %0d results checked", commands_sent, results_checked);
        $display("status mix: ok %0d, full %0d, empty %0d, out of span %0d",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
                 status_seen[ST_SPAN]);
        if (errors == 0)
            $display("tb_indexed_ring_table_core: clean");
        else
            $display("tb_indexed_ring_table_core: errors");
        $finish;
    end

endmodule
